@@ design/mma_pkg.sv @@
// Shared constants, types and helpers for the matrix multiply-accumulate block.
package mma_pkg;

  localparam int MAX_DIM   = 32;
  localparam int FRAC_BITS = 16;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  // Field widths of the stream beats
  localparam int OP_W   = 3;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int SIZE_W = 6;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  // Configuration register indexes
  localparam logic [1:0] CFG_INNER_SIZE = 2'd0;
  localparam logic [1:0] CFG_OUT_COLS   = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_Q  = 3'd0,
    OP_LOAD_S  = 3'd1,
    OP_LOAD_R  = 3'd2,
    OP_START   = 3'd3,
    OP_READ_R  = 3'd4
  } op_t;

  // Control into the shared multiply-accumulate unit
  typedef struct packed {
    logic init;  // load the accumulator from init_val
    logic vld;   // operands valid this cycle
  } mac_ctl_t;

  // Status out of the shared multiply-accumulate unit
  typedef struct packed {
    logic busy;  // a product is still on its way to the accumulator
    logic sat;   // the update in this cycle clipped
  } mac_sts_t;

  function automatic logic [ADDR_W-1:0] mk_addr(input int r, input int c);
    int a;
    begin
      a = r * MAX_DIM + c;
      return a[ADDR_W-1:0];
    end
  endfunction

  function automatic logic pos_ok(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c);
    begin
      return (int'(r) < MAX_DIM) && (int'(c) < MAX_DIM);
    end
  endfunction

  function automatic logic [CNT_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    begin
      if (int'(v) > MAX_DIM) begin
        return CNT_W'(MAX_DIM);
      end
      return CNT_W'(v);
    end
  endfunction

endpackage

@@ design/matrix_multiply_accumulate.sv @@
// Top level: stream front end, element stores and compute sequencer for R += Q * S.
//
// Usage: each beat on the in_ channel carries an operation, a row, a column and
// a Q16.16 value. Load Q, load S and preload R write one element; read R returns
// one element; start runs R += Q * S over the sizes in the configuration
// registers. Every beat gets exactly one out_ beat holding the read data (zero
// for other operations) and the saturation flag of the last compute.
// Loads and unknown operations may come back to back; their answer appears the
// cycle after acceptance. A read waits in RD_WAIT for the registered store read.
// A start runs R += Q * S element by element: one multiply-accumulate per cycle
// on the shared unit while issuing, then a fill, drain and write-back of each result
// element through the accumulator store's single read and write port.
// in_tready is low while a read or compute runs, and while an answer waits
// in the output register and out_tready is low; a stalled receiver only holds
// the block, nothing is dropped.
// Reset clears the control state, the saturation flag and sets both sizes to 32;
// the element stores hold nothing defined until written.
module matrix_multiply_accumulate
  import mma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // operation [2:0], row [7:3], col [12:8], value [44:13]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // data [31:0], saturated [32]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [SIZE_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_ISSUE,
    ST_DRAIN,
    ST_RESP
  } state_t;

  state_t state_r;

  logic [SIZE_W-1:0] inner_size_r, out_cols_r;
  logic [CNT_W-1:0]  m_r, p_r;
  logic [IDX_W-1:0]  i_r, j_r, k_r;
  logic              sat_r;
  logic              iss_r, init_r, rd_ok_r;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_data_r;
  logic              out_sat_r;

  op_t               op;
  logic [POS_W-1:0]  row, col;
  logic [VAL_W-1:0]  value;
  logic              in_acc, out_free, ok;
  logic              resp_now;
  logic [ADDR_W-1:0] in_addr;

  logic              q_we, s_we, r_we;
  logic [ADDR_W-1:0] q_raddr, s_raddr, r_raddr, r_waddr;
  logic [VAL_W-1:0]  r_wdata;
  logic [VAL_W-1:0]  q_rdata, s_rdata, r_rdata;

  mac_ctl_t          mac_ctl;
  mac_sts_t          mac_sts;
  logic signed [VAL_W-1:0] mac_acc;

  logic issuing, wb, last_k, last_j, last_i;

  assign op      = op_t'(in_tdata[2:0]);
  assign row     = in_tdata[7:3];
  assign col     = in_tdata[12:8];
  assign value   = in_tdata[44:13];
  assign ok      = pos_ok(row, col);
  assign in_addr = mk_addr(int'(row), int'(col));

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  // a new answer enters the output register this cycle
  assign resp_now = (state_r == ST_RD_WAIT) || (state_r == ST_RESP) ||
                    (in_acc && (op != OP_START) && (op != OP_READ_R));

  assign last_k  = int'(k_r) == int'(m_r) - 1;
  assign last_j  = int'(j_r) == int'(p_r) - 1;
  assign last_i  = int'(i_r) == int'(m_r) - 1;
  assign issuing = state_r == ST_ISSUE;
  // write back once the last product has landed in the accumulator
  assign wb      = (state_r == ST_DRAIN) && !iss_r && !mac_sts.busy;

  always_comb begin
    q_we    = in_acc && ok && (op == OP_LOAD_Q);
    s_we    = in_acc && ok && (op == OP_LOAD_S);
    r_we    = (in_acc && ok && (op == OP_LOAD_R)) || wb;
    r_waddr = wb ? mk_addr(int'(i_r), int'(j_r)) : in_addr;
    r_wdata = wb ? mac_acc : value;
    r_raddr = (state_r == ST_IDLE) ? in_addr : mk_addr(int'(i_r), int'(j_r));
    q_raddr = mk_addr(int'(i_r), int'(k_r));
    s_raddr = mk_addr(int'(k_r), int'(j_r));
  end

  mma_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_q_ram (
    .clk(clk), .we(q_we), .waddr(in_addr), .wdata(value),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  mma_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_s_ram (
    .clk(clk), .we(s_we), .waddr(in_addr), .wdata(value),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  mma_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_r_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  assign mac_ctl.init = init_r;
  assign mac_ctl.vld  = iss_r;

  mma_mac u_mac (
    .clk(clk), .rst_n(rst_n), .ctl(mac_ctl),
    .init_val(r_rdata), .q_val(q_rdata), .s_val(s_rdata),
    .acc(mac_acc), .sts(mac_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      inner_size_r <= SIZE_W'(32);
      out_cols_r   <= SIZE_W'(32);
      sat_r        <= 1'b0;
      iss_r        <= 1'b0;
      init_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INNER_SIZE: inner_size_r <= cfg_wdata;
          CFG_OUT_COLS:   out_cols_r   <= cfg_wdata;
          default: ;
        endcase
      end

      iss_r  <= issuing;
      init_r <= issuing && (k_r == '0);
      if (mac_sts.sat) begin
        sat_r <= 1'b1;
      end

      // raise valid for a new answer, drop it once the receiver takes the beat
      if (resp_now) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (op)
              OP_START: begin
                sat_r <= 1'b0;
                m_r   <= eff_size(inner_size_r);
                p_r   <= eff_size(out_cols_r);
                i_r   <= '0;
                j_r   <= '0;
                k_r   <= '0;
                if (eff_size(inner_size_r) == '0 || eff_size(out_cols_r) == '0) begin
                  state_r <= ST_RESP;
                end else begin
                  state_r <= ST_ISSUE;
                end
              end
              OP_READ_R: begin
                rd_ok_r <= ok;
                state_r <= ST_RD_WAIT;
              end
              default: begin
                out_data_r  <= '0;
                out_sat_r   <= sat_r;
              end
            endcase
          end
        end
        ST_RD_WAIT: begin
          out_data_r  <= rd_ok_r ? r_rdata : '0;
          out_sat_r   <= sat_r;
          state_r     <= ST_IDLE;
        end
        ST_ISSUE: begin
          if (last_k) begin
            k_r     <= '0;
            state_r <= ST_DRAIN;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (wb) begin
            if (last_j) begin
              j_r <= '0;
              if (last_i) begin
                state_r <= ST_RESP;
              end else begin
                i_r     <= i_r + 1'b1;
                state_r <= ST_ISSUE;
              end
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= ST_ISSUE;
            end
          end
        end
        ST_RESP: begin
          out_data_r  <= '0;
          out_sat_r   <= sat_r;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_sat_r, out_data_r};

endmodule

@@ design/mma_ram.sv @@
// Simple dual-port RAM: one write port, one registered read port.
module mma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/mma_mac.sv @@
// Shared multiply, shift and saturating accumulate unit.
module mma_mac
  import mma_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctl_t                ctl,
  input  logic signed [VAL_W-1:0] init_val,
  input  logic signed [VAL_W-1:0] q_val,
  input  logic signed [VAL_W-1:0] s_val,
  output logic signed [VAL_W-1:0] acc,
  output mac_sts_t                sts
);

  localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
  localparam logic signed [64:0] SAT_LO = -65'sd2147483648;

  logic signed [63:0] prod_r;
  logic               prod_vld_r;
  logic signed [VAL_W-1:0] acc_r, acc_nxt;
  logic signed [63:0] sh;
  logic signed [64:0] sum;
  logic               clip;

  always_comb begin
    sh   = prod_r >>> FRAC_BITS;
    sum  = {{33{acc_r[VAL_W-1]}}, acc_r} + {sh[63], sh};
    clip = 1'b0;
    if (sum > SAT_HI) begin
      acc_nxt = VAL_W'(SAT_HI);
      clip    = 1'b1;
    end else if (sum < SAT_LO) begin
      acc_nxt = VAL_W'(SAT_LO);
      clip    = 1'b1;
    end else begin
      acc_nxt = sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.vld;
    end
    prod_r <= 64'(q_val) * 64'(s_val);
    if (ctl.init) begin
      acc_r <= init_val;
    end else if (prod_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc      = acc_r;
  assign sts.busy = prod_vld_r;
  assign sts.sat  = prod_vld_r && !ctl.init && clip;

endmodule

@@ dv/matrix_multiply_accumulate_test.sv @@
// Self-checking stream testbench for the R += Q * S multiply-accumulate block.
module matrix_multiply_accumulate_test;
  import mma_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Highest code the operation field can carry; codes above OP_READ_R do nothing
  localparam logic [OP_W-1:0] OP_TOP_CODE = '1;
  localparam longint ELEM_MAX = 64'sd2147483647;
  localparam longint ELEM_MIN = -64'sd2147483648;

  typedef struct {
    int data;
    bit sat;
  } answer_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // operation [2:0], row [7:3], col [12:8], value [44:13]
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // data [31:0], saturated [32]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = '0;
  logic [SIZE_W-1:0]     cfg_wdata = '0;

  // Mirror of the block's stores, sizes and flag
  int              q_mirror [DEPTH];
  int              s_mirror [DEPTH];
  int              r_mirror [DEPTH];
  bit              q_set [DEPTH];
  bit              s_set [DEPTH];
  bit              r_set [DEPTH];
  bit              sat_mirror = 1'b0;
  logic [SIZE_W-1:0] inner_reg = 6'd32;
  logic [SIZE_W-1:0] cols_reg = 6'd32;

  answer_t pending_answers[$];
  int      error_count = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      rx_hold = 0;

  matrix_multiply_accumulate u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_dim(input logic [SIZE_W-1:0] v);
    return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  // R += Q * S with floor-shifted products and 32-bit saturation at every step
  function automatic void run_mac_pass();
    int m;
    int p;
    longint acc;
    longint prod;
    m = clamp_dim(inner_reg);
    p = clamp_dim(cols_reg);
    sat_mirror = 1'b0;
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < p; j++) begin
        acc = longint'(r_mirror[i * MAX_DIM + j]);
        for (int k = 0; k < m; k++) begin
          prod = longint'(q_mirror[i * MAX_DIM + k]) * longint'(s_mirror[k * MAX_DIM + j]);
          acc += prod >>> FRAC_BITS;
          if (acc > ELEM_MAX) begin
            acc = ELEM_MAX;
            sat_mirror = 1'b1;
          end else if (acc < ELEM_MIN) begin
            acc = ELEM_MIN;
            sat_mirror = 1'b1;
          end
        end
        r_mirror[i * MAX_DIM + j] = int'(acc);
        r_set[i * MAX_DIM + j] = 1'b1;
      end
    end
  endfunction

  function automatic answer_t predict_answer(input logic [OP_W-1:0] op, input int row,
                                             input int col, input int value);
    answer_t ans;
    int addr;
    addr = row * MAX_DIM + col;
    ans.data = 0;
    case (op)
      OP_LOAD_Q: begin
        q_mirror[addr] = value;
        q_set[addr] = 1'b1;
      end
      OP_LOAD_S: begin
        s_mirror[addr] = value;
        s_set[addr] = 1'b1;
      end
      OP_LOAD_R: begin
        r_mirror[addr] = value;
        r_set[addr] = 1'b1;
      end
      OP_START: run_mac_pass();
      OP_READ_R: ans.data = r_mirror[addr];
      default: ;
    endcase
    ans.sat = sat_mirror;
    return ans;
  endfunction

  function automatic int rand_element();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 0;
          3: return -1;
          default: return 32'h0001_0000;
        endcase
      end
      1, 2, 3: return int'($urandom);
      default: return int'($urandom_range(1 << 19)) - (1 << 18);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    error_count++;
  endtask

  // Check each beat that the receiver takes at the coming edge
  always @(negedge clk) begin : answer_check
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected beat", '0, out_tdata[31:0]);
      end else begin
        want = pending_answers.pop_front();
        if (out_tdata[31:0] !== 32'(want.data)) begin
          report_mismatch("data", 32'(want.data), out_tdata[31:0]);
        end
        if (out_tdata[32] !== want.sat) begin
          report_mismatch("saturated", 32'(want.sat), 32'(out_tdata[32]));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_beat(input logic [OP_W-1:0] op, input int row, input int col,
                           input int value);
    int gap;
    bit ok;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, 32'(value), POS_W'(col), POS_W'(row), op};
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    pending_answers.push_back(predict_answer(op, row, col, value));
  endtask

  // Drop valid, let every answer come back, then let the block settle while idle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_INNER_SIZE) begin
      inner_reg = val;
    end else if (idx == CFG_OUT_COLS) begin
      cols_reg = val;
    end
  endtask

  // Load every element that the next compute will read and that holds nothing yet
  task automatic fill_operands();
    int m;
    int p;
    m = clamp_dim(inner_reg);
    p = clamp_dim(cols_reg);
    for (int i = 0; i < m; i++) begin
      for (int k = 0; k < m; k++) begin
        if (!q_set[i * MAX_DIM + k]) send_beat(OP_LOAD_Q, i, k, rand_element());
      end
    end
    for (int k = 0; k < m; k++) begin
      for (int j = 0; j < p; j++) begin
        if (!s_set[k * MAX_DIM + j]) send_beat(OP_LOAD_S, k, j, rand_element());
      end
    end
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < p; j++) begin
        if (!r_set[i * MAX_DIM + j]) send_beat(OP_LOAD_R, i, j, rand_element());
      end
    end
  endtask

  task automatic test_directed();
    write_reg(CFG_INNER_SIZE, 6'd2);
    write_reg(CFG_OUT_COLS, 6'd2);
    // indexes past the last register must be ignored
    for (int i = CFG_OUT_COLS + 1; i < 2 ** $bits(cfg_index); i++) begin
      write_reg(2'(i), SIZE_W'($urandom));
    end
    send_beat(OP_LOAD_Q, 0, 0, 32'h7FFF_FFFF);
    send_beat(OP_LOAD_Q, 0, 1, 32'h7FFF_FFFF);
    send_beat(OP_LOAD_Q, 1, 0, 32'h8000_0000);
    send_beat(OP_LOAD_Q, 1, 1, 32'h0000_0001);
    send_beat(OP_LOAD_S, 0, 0, 32'h7FFF_FFFF);
    send_beat(OP_LOAD_S, 0, 1, -1);
    send_beat(OP_LOAD_S, 1, 0, 32'h8000_0000);
    send_beat(OP_LOAD_S, 1, 1, 32'h0001_0000);
    send_beat(OP_LOAD_R, 0, 0, 0);
    send_beat(OP_LOAD_R, 0, 1, 32'h7FFF_FFFF);
    send_beat(OP_LOAD_R, 1, 0, 32'h8000_0000);
    send_beat(OP_LOAD_R, 1, 1, -1);
    send_beat(OP_START, 31, 31, -1);
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) send_beat(OP_READ_R, i, j, 0);
    end
    for (int op = OP_READ_R + 1; op <= OP_TOP_CODE; op++) begin
      send_beat(OP_W'(op), 31, 31, int'($urandom));
    end
    send_beat(OP_LOAD_Q, 31, 31, 32'h8000_0000);
    send_beat(OP_LOAD_S, 31, 31, 32'h7FFF_FFFF);
    send_beat(OP_LOAD_R, 31, 31, 32'h5A5A_A5A5);
    send_beat(OP_READ_R, 31, 31, -1);
    wait_idle();
  endtask

  // A compute with either size at zero updates nothing and clears the flag
  task automatic test_zero_sizes();
    write_reg(CFG_INNER_SIZE, 6'd0);
    send_beat(OP_START, 0, 0, 0);
    wait_idle();
    write_reg(CFG_INNER_SIZE, 6'd2);
    send_beat(OP_START, 0, 0, 0);
    wait_idle();
    write_reg(CFG_OUT_COLS, 6'd0);
    send_beat(OP_START, 0, 0, 0);
    send_beat(OP_READ_R, 1, 1, 0);
    wait_idle();
  endtask

  // Sizes above the store dimension clamp to 32; a wide column count runs all 32 columns
  task automatic test_full_size();
    write_reg(CFG_INNER_SIZE, '1);
    write_reg(CFG_OUT_COLS, 6'd0);
    send_beat(OP_START, 0, 0, 0);
    wait_idle();
    write_reg(CFG_INNER_SIZE, 6'd1);
    write_reg(CFG_OUT_COLS, '1);
    fill_operands();
    send_beat(OP_START, 0, 0, 0);
    repeat (12) send_beat(OP_READ_R, 0, $urandom_range(MAX_DIM - 1), 0);
    wait_idle();
  endtask

  // Hold the receiver for a long stretch while loads keep coming
  task automatic test_backpressure();
    int saved_tx;
    saved_tx = tx_idle_pct;
    tx_idle_pct = 0;
    rx_hold = 300;
    repeat (60) send_beat(OP_W'($urandom_range(OP_LOAD_R)), $urandom_range(MAX_DIM - 1),
                          $urandom_range(MAX_DIM - 1), rand_element());
    tx_idle_pct = saved_tx;
    wait_idle();
  endtask

  task automatic test_random(input int n_items);
    int done;
    int pick;
    int m;
    int p;
    int row;
    int col;
    done = 0;
    while (done < n_items) begin
      if (done % 40 == 0) begin
        wait_idle();
        write_reg(CFG_INNER_SIZE, SIZE_W'(($urandom_range(7) == 0) ? 8 : $urandom_range(1, 6)));
        write_reg(CFG_OUT_COLS, SIZE_W'(($urandom_range(7) == 0) ? 8 : $urandom_range(0, 6)));
      end
      m = clamp_dim(inner_reg);
      p = clamp_dim(cols_reg);
      pick = $urandom_range(99);
      if (pick < 10) begin
        fill_operands();
        send_beat(OP_START, $urandom_range(MAX_DIM - 1), $urandom_range(MAX_DIM - 1),
                  int'($urandom));
        done++;
      end else if (pick < 40) begin
        if (p > 0 && $urandom_range(9) != 0) begin
          row = $urandom_range(m - 1);
          col = $urandom_range(p - 1);
        end else begin
          row = $urandom_range(MAX_DIM - 1);
          col = $urandom_range(MAX_DIM - 1);
        end
        // never read an element that was not written; preload it instead
        if (r_set[row * MAX_DIM + col]) begin
          send_beat(OP_READ_R, row, col, int'($urandom));
        end else begin
          send_beat(OP_LOAD_R, row, col, rand_element());
        end
        done++;
      end else if (pick < 45) begin
        send_beat(OP_W'($urandom_range(OP_TOP_CODE, OP_READ_R + 1)),
                  $urandom_range(MAX_DIM - 1), $urandom_range(MAX_DIM - 1), int'($urandom));
      end else begin
        if ($urandom_range(9) < 7) begin
          row = $urandom_range(m - 1);
          col = $urandom_range(((m > p) ? m : p) - 1);
        end else begin
          row = $urandom_range(MAX_DIM - 1);
          col = $urandom_range(MAX_DIM - 1);
        end
        send_beat(OP_W'($urandom_range(OP_LOAD_R)), row, col, rand_element());
        done++;
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 7;
    rx_idle_pct = 63;
    test_directed();
    test_zero_sizes();
    test_random(70);

    tx_idle_pct = 63;
    rx_idle_pct = 7;
    test_backpressure();
    test_full_size();
    test_random(70);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(70);

    wait_idle();
    repeat (20) @(posedge clk);
    if (pending_answers.size() != 0) begin
      report_mismatch("beats never returned", '0, 32'(pending_answers.size()));
    end
    if (error_count == 0) begin
      $display("matrix_multiply_accumulate verification clean");
    end else begin
      $display("matrix_multiply_accumulate verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("matrix_multiply_accumulate verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/mma_pkg.sv
design/mma_ram.sv
design/mma_mac.sv
design/matrix_multiply_accumulate.sv
dv/matrix_multiply_accumulate_test.sv
